[rtl/disk_request_scheduler_assert.svh]
// assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DRS_ASSERT_SAME(lbl, ante, cons, msg)
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/dsched_pkg.sv]
// shared types and constants of the disk request scheduler
`timescale 1ns / 1ps
package dsched_pkg;
	localparam int FIELD_W   = 12;
	localparam int SUM_W     = 18;
	localparam int CFG_W     = 12;
	localparam int REG_IDX_W = 1;

	localparam logic [FIELD_W-1:0] START_RESET = 12'd100;
	localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

	typedef enum logic [1:0] {
		POL_FCFS  = 2'd0,
		POL_SSTF  = 2'd1,
		POL_SCAN  = 2'd2,
		POL_CSCAN = 2'd3
	} policy_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_POLICY = 1'b0,
		REG_START  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		policy_t policy;
		logic    down;
		logic    pass2;
	} cmp_ctl_t;
endpackage

[rtl/dsched_cmp.sv]
// shared seek compare unit: distance, eligibility and best-candidate test
`timescale 1ns / 1ps
module dsched_cmp #(
	parameter int TRACK_BITS = 12
) (
	input  dsched_pkg::cmp_ctl_t  ctl,
	input  logic [TRACK_BITS-1:0] trk,
	input  logic [TRACK_BITS-1:0] head,
	input  logic [TRACK_BITS-1:0] best_key,
	input  logic                  found,
	input  logic                  unserved,
	output logic                  take,
	output logic [TRACK_BITS-1:0] gap,
	output logic [TRACK_BITS-1:0] key
);
	import dsched_pkg::*;

	logic above;
	logic elig;

	always_comb begin
		above = trk > head;
		gap   = above ? trk - head : head - trk;
		case (ctl.policy)
			POL_FCFS: begin
				elig = 1'b1;
				key  = '0;
			end
			POL_SSTF: begin
				elig = 1'b1;
				key  = gap;
			end
			POL_SCAN: begin
				elig = ctl.down ? !above : (trk >= head);
				key  = gap;
			end
			POL_CSCAN: begin
				elig = ctl.pass2 ? 1'b1 : above;
				key  = trk;
			end
			default: begin
				elig = 1'b0;
				key  = '0;
			end
		endcase
		take = unserved && elig && (!found || (key < best_key));
	end
endmodule

[rtl/dsched_store.sv]
// request memory with one read port and per-entry served flags
`timescale 1ns / 1ps
module dsched_store #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TRACK_BITS  = 12,
	parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [TRACK_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [TRACK_BITS-1:0] rd_data,
	input  logic [IDX_W-1:0]      chk_idx,
	output logic                  unserved,
	input  logic                  set_en,
	input  logic [IDX_W-1:0]      set_idx,
	input  logic                  clear_all
);
	logic [TRACK_BITS-1:0]  mem [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0]  rd_data_q;
	logic [QUEUE_DEPTH-1:0] served_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q <= '0;
		end else if (clear_all) begin
			served_q <= '0;
		end else if (set_en) begin
			served_q[set_idx] <= 1'b1;
		end
	end

	assign rd_data  = rd_data_q;
	assign unserved = !served_q[chk_idx];
endmodule

[rtl/disk_request_scheduler.sv]
// top level of the disk request scheduler: sequencer, config and result registers
//
// requests enter one at a time: a request is taken at a clock edge with start high
// and busy low, carrying request_track and batch_end. requests beyond QUEUE_DEPTH
// are dropped. a request without batch_end is stored and busy stays low.
// a request with batch_end starts scheduling: busy rises and stays high until the
// last result of the batch has been issued.
// each result is served_track, seek_distance, total_movement and order_end, shown
// for exactly one cycle with result_strobe; the receiver cannot stall.
// every result needs a scan of the n stored requests through the shared compare
// unit and request memory read port, a second pass when scan reverses or circular
// scan wraps, and then an issue state. policy and start_track are to be written
// through wr_en, wr_index and wr_data only while idle; the block does not enforce it.
// reset clears served flags, the request count, the sequencer and the registers:
// policy to first come first served, start_track to 100.
`timescale 1ns / 1ps
`include "disk_request_scheduler_assert.svh"
module disk_request_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TRACK_BITS  = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [dsched_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [dsched_pkg::CFG_W-1:0]       wr_data,
	input  logic                               start,
	output logic                               busy,
	input  logic [dsched_pkg::FIELD_W-1:0]     request_track,
	input  logic                               batch_end,
	output logic                               result_strobe,
	output logic [dsched_pkg::FIELD_W-1:0]     served_track,
	output logic [dsched_pkg::FIELD_W-1:0]     seek_distance,
	output logic [dsched_pkg::SUM_W-1:0]       total_movement,
	output logic                               order_end
);
	import dsched_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t                state_q;
	policy_t               policy_q;
	logic [CFG_W-1:0]      start_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      served_cnt_q;
	logic [TRACK_BITS-1:0] head_q;
	logic                  down_q;
	logic                  pass2_q;
	logic [SUM_W-1:0]      sum_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  issue_q;
	logic                  eval_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  found_q;
	logic [TRACK_BITS-1:0] best_key_q;
	logic [TRACK_BITS-1:0] best_trk_q;
	logic [TRACK_BITS-1:0] best_gap_q;
	logic [IDX_W-1:0]      best_idx_q;

	logic                  strobe_q;
	logic [FIELD_W-1:0]    served_track_q;
	logic [FIELD_W-1:0]    seek_distance_q;
	logic [SUM_W-1:0]      total_q;
	logic                  order_end_q;

	logic                  accept;
	logic                  store_ok;
	logic [TRACK_BITS-1:0] trk_in;
	logic [TRACK_BITS-1:0] rd_data;
	logic                  unserved;
	logic                  take;
	logic                  take_v;
	logic [TRACK_BITS-1:0] gap;
	logic [TRACK_BITS-1:0] key;
	cmp_ctl_t              cmp_ctl;
	logic [IDX_W-1:0]      last_idx;
	logic                  pass_done;
	logic                  found_next;
	logic                  last_result;
	logic [SUM_W:0]        sum_add;
	logic [SUM_W-1:0]      sum_next;

	assign accept      = start && !busy;
	assign store_ok    = count_q < CNT_W'(QUEUE_DEPTH);
	assign trk_in      = TRACK_BITS'(request_track);
	assign last_idx    = IDX_W'(count_q - CNT_W'(1));
	assign take_v      = eval_s1 && take;
	assign pass_done   = eval_s1 && (idx_s1 == last_idx);
	assign found_next  = found_q || take_v;
	assign last_result = (served_cnt_q + CNT_W'(1)) == count_q;
	assign sum_add     = {1'b0, sum_q} + (SUM_W + 1)'(best_gap_q);
	assign sum_next    = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

	assign cmp_ctl.policy = policy_q;
	assign cmp_ctl.down   = down_q;
	assign cmp_ctl.pass2  = pass2_q;

	dsched_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_BITS (TRACK_BITS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && store_ok),
		.wr_addr  (count_q[IDX_W-1:0]),
		.wr_data  (trk_in),
		.rd_en    (issue_q),
		.rd_addr  (addr_q),
		.rd_data  (rd_data),
		.chk_idx  (idx_s1),
		.unserved (unserved),
		.set_en   (state_q == S_EMIT),
		.set_idx  (best_idx_q),
		.clear_all(state_q == S_EMIT && last_result)
	);

	dsched_cmp #(
		.TRACK_BITS(TRACK_BITS)
	) u_cmp (
		.ctl     (cmp_ctl),
		.trk     (rd_data),
		.head    (head_q),
		.best_key(best_key_q),
		.found   (found_q),
		.unserved(unserved),
		.take    (take),
		.gap     (gap),
		.key     (key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
			start_q  <= START_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_POLICY: policy_q <= policy_t'(wr_data[1:0]);
				REG_START:  start_q  <= wr_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_v) begin
			best_key_q <= key;
			best_trk_q <= rd_data;
			best_gap_q <= gap;
			best_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			served_cnt_q    <= '0;
			head_q          <= TRACK_BITS'(START_RESET);
			down_q          <= 1'b1;
			pass2_q         <= 1'b0;
			sum_q           <= '0;
			addr_q          <= '0;
			issue_q         <= 1'b0;
			eval_s1         <= 1'b0;
			idx_s1          <= '0;
			found_q         <= 1'b0;
			strobe_q        <= 1'b0;
			served_track_q  <= '0;
			seek_distance_q <= '0;
			total_q         <= '0;
			order_end_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			eval_s1  <= issue_q;
			idx_s1   <= addr_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (batch_end) begin
							head_q       <= TRACK_BITS'(start_q);
							down_q       <= 1'b1;
							sum_q        <= '0;
							served_cnt_q <= '0;
							pass2_q      <= 1'b0;
							found_q      <= 1'b0;
							addr_q       <= '0;
							issue_q      <= 1'b1;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						addr_q <= addr_q + IDX_W'(1);
						if (addr_q == last_idx) begin
							issue_q <= 1'b0;
						end
					end
					if (take_v) begin
						found_q <= 1'b1;
					end
					if (pass_done) begin
						if (found_next) begin
							state_q <= S_EMIT;
						end else begin
							if (policy_q == POL_SCAN) begin
								down_q <= !down_q;
							end
							pass2_q <= 1'b1;
							found_q <= 1'b0;
							addr_q  <= '0;
							issue_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					strobe_q        <= 1'b1;
					served_track_q  <= FIELD_W'(best_trk_q);
					seek_distance_q <= FIELD_W'(best_gap_q);
					total_q         <= sum_next;
					order_end_q     <= last_result;
					sum_q           <= sum_next;
					head_q          <= best_trk_q;
					served_cnt_q    <= served_cnt_q + CNT_W'(1);
					pass2_q         <= 1'b0;
					found_q         <= 1'b0;
					addr_q          <= '0;
					if (last_result) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						issue_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q != S_IDLE;
	assign result_strobe  = strobe_q;
	assign served_track   = served_track_q;
	assign seek_distance  = seek_distance_q;
	assign total_movement = total_q;
	assign order_end      = order_end_q && strobe_q;

	`DRS_ASSERT_SAME(a_strobe_after_busy, result_strobe, $past(busy), "result without scheduling")
	`DRS_ASSERT_NEXT(a_batch_starts, start && !busy && batch_end, busy, "batch end did not schedule")
	`DRS_ASSERT_SAME(a_emit_has_pick, state_q == S_EMIT, found_q, "issue without a chosen request")
	`DRS_ASSERT_SAME(a_emit_in_range, state_q == S_EMIT, served_cnt_q < count_q, "too many results")
endmodule
